>>> hw/rtl/spvm_pkg.sv
// spvm_pkg: shared types and constants for the stereo pan/volume mixer.
// No dependencies; imported by every module of the block.

package spvm_pkg;

    localparam int unsigned VOL_FULL_SCALE = 255;
    localparam logic [7:0]  PAN_CENTER     = 8'd128;
    localparam logic [8:0]  SAMPLE8_BIAS   = 9'd127;
    localparam logic [7:0]  OUT8_BIAS      = 8'd127;
    localparam logic [7:0]  MASTER_VOL_RST = 8'd128;

    // register indexes on the config port
    localparam logic REG_MASTER_VOLUME = 1'b0;
    localparam logic REG_OUTPUT_8BIT   = 1'b1;

    // one classified contribution handed from front end to back end
    typedef struct packed {
        logic signed [15:0] sample;
        logic               is8;
        logic [9:0]         gain;
        logic [7:0]         left_share;
        logic [7:0]         right_share;
        logic               last;
    } spvm_item_t;

endpackage

>>> hw/rtl/spvm_front.sv
// spvm_front: input stage; pan shares, volume product, then gain = x / 255.
// Depends on spvm_pkg.

module spvm_front
    import spvm_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic signed [15:0] sample_value,
    input  logic               sample_is_8bit,
    input  logic [7:0]         channel_volume,
    input  logic signed [7:0]  pan,
    input  logic               last_of_frame,
    input  logic [7:0]         master_volume,
    output logic               push_valid,
    input  logic               push_ready,
    output spvm_item_t         push_item
);

    logic               s1_valid_reg, s1_valid_next;
    logic signed [15:0] s1_sample_reg, s1_sample_next;
    logic               s1_is8_reg, s1_is8_next;
    logic [7:0]         s1_left_reg, s1_left_next;
    logic [7:0]         s1_right_reg, s1_right_next;
    logic               s1_last_reg, s1_last_next;
    logic [15:0]        s1_prod_reg, s1_prod_next;
    logic               s2_valid_reg, s2_valid_next;
    spvm_item_t         s2_item_reg, s2_item_next;

    logic        s2_free;
    logic        s1_move;
    logic        in_take;
    logic [16:0] vol_prod;
    logic [16:0] x;
    logic [25:0] x_recip;
    logic [9:0]  q0;
    logic [17:0] q0_x255;
    logic [17:0] rem;
    logic [9:0]  gain;

    assign s2_free  = !s2_valid_reg || push_ready;
    assign s1_move  = s1_valid_reg && s2_free;
    assign in_ready = !s1_valid_reg || s2_free;
    assign in_take  = in_valid && in_ready;

    // stage 1: (vol + 1) * master, pan split
    assign vol_prod = 17'({1'b0, channel_volume} + 9'd1) * 17'(master_volume);

    always_comb
    begin
        s1_sample_next = sample_value;
        s1_is8_next    = sample_is_8bit;
        s1_last_next   = last_of_frame;
        s1_prod_next   = vol_prod[15:0];
        if (pan[7])
        begin
            s1_left_next  = PAN_CENTER;
            s1_right_next = PAN_CENTER + pan;
        end
        else
        begin
            s1_left_next  = PAN_CENTER - pan;
            s1_right_next = PAN_CENTER;
        end
    end

    // stage 2: x / 255 via x*257 >> 16, then one correction step
    assign x       = {s1_prod_reg, 1'b0};
    assign x_recip = {1'b0, x, 8'd0} + 26'(x);
    assign q0      = x_recip[25:16];
    assign q0_x255 = {q0, 8'd0} - 18'(q0);
    assign rem     = 18'(x) - q0_x255;
    assign gain    = (rem >= 18'(VOL_FULL_SCALE)) ? q0 + 10'd1 : q0;

    always_comb
    begin
        s2_item_next.sample      = s1_sample_reg;
        s2_item_next.is8         = s1_is8_reg;
        s2_item_next.gain        = gain;
        s2_item_next.left_share  = s1_left_reg;
        s2_item_next.right_share = s1_right_reg;
        s2_item_next.last        = s1_last_reg;
    end

    always_comb
    begin
        s1_valid_next = s1_valid_reg;
        if (in_take)
            s1_valid_next = 1'b1;
        else if (s1_move)
            s1_valid_next = 1'b0;

        s2_valid_next = s2_valid_reg;
        if (s1_move)
            s2_valid_next = 1'b1;
        else if (push_ready)
            s2_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= s1_valid_next;
            s2_valid_reg <= s2_valid_next;
            if (in_take)
            begin
                s1_sample_reg <= s1_sample_next;
                s1_is8_reg    <= s1_is8_next;
                s1_left_reg   <= s1_left_next;
                s1_right_reg  <= s1_right_next;
                s1_last_reg   <= s1_last_next;
                s1_prod_reg   <= s1_prod_next;
            end
            if (s1_move)
                s2_item_reg <= s2_item_next;
        end
    end

    assign push_valid = s2_valid_reg;
    assign push_item  = s2_item_reg;

endmodule

>>> hw/rtl/spvm_queue.sv
// spvm_queue: small FIFO of classified contributions between front and back end.
// Depends on spvm_pkg.

module spvm_queue
    import spvm_pkg::*;
#(
    parameter int DEPTH = 2
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       push_valid,
    output logic       push_ready,
    input  spvm_item_t push_item,
    output logic       pop_valid,
    input  logic       pop_ready,
    output spvm_item_t pop_item
);

    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    spvm_item_t       entry_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             do_push;
    logic             do_pop;

    assign push_ready = (count_reg != CNT_W'(DEPTH));
    assign pop_valid  = (count_reg != '0);
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop_valid && pop_ready;
    assign pop_item   = entry_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        if (do_pop)
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        if (do_push && !do_pop)
            count_next = count_reg + 1'b1;
        else if (do_pop && !do_push)
            count_next = count_reg - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
            entry_reg[wr_ptr_reg] <= push_item;
    end

endmodule

>>> hw/rtl/spvm_back.sv
// spvm_back: scales each contribution, accumulates left/right, clips at frame end.
// Depends on spvm_pkg.

module spvm_back
    import spvm_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        item_valid,
    output logic        item_ready,
    input  spvm_item_t  item,
    input  logic        output_8bit,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [15:0] left_out,
    output logic [15:0] right_out
);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_ACC,
        ST_OUT
    } state_t;

    state_t             state_reg, state_next;
    logic signed [17:0] v_reg, v_next;
    logic [7:0]         left_reg, left_next;
    logic [7:0]         right_reg, right_next;
    logic               last_reg, last_next;
    logic [31:0]        acc_l_reg, acc_l_next;
    logic [31:0]        acc_r_reg, acc_r_next;
    logic [15:0]        out_l_reg, out_l_next;
    logic [15:0]        out_r_reg, out_r_next;
    logic               out_valid_reg, out_valid_next;

    logic signed [8:0]  v8;
    logic signed [15:0] mul_a;
    logic signed [10:0] mul_b;
    logic signed [26:0] prod;
    logic signed [26:0] prod_adj;
    logic signed [17:0] v_calc;
    logic signed [26:0] pl;
    logic signed [26:0] pr;
    logic signed [26:0] pl_adj;
    logic signed [26:0] pr_adj;
    logic signed [18:0] dl;
    logic signed [18:0] dr;

    function automatic logic [15:0] clip_sample(input logic signed [31:0] acc,
                                                input logic mode8);
        logic signed [31:0] adj;
        logic signed [23:0] s;
        logic [15:0]        r;
        adj = acc + (acc[31] ? 32'sd255 : 32'sd0);
        s   = adj[31:8];
        if (mode8)
        begin
            if (s > 24'sd127)
                r = 16'd255;
            else if (s < -24'sd127)
                r = 16'd0;
            else
                r = {8'd0, s[7:0] + OUT8_BIAS};
        end
        else
        begin
            if (acc > 32'sd32767)
                r = 16'h7fff;
            else if (acc < -32'sd32768)
                r = 16'h8000;
            else
                r = acc[15:0];
        end
        return r;
    endfunction

    // sample * gain; 16-bit path divides by 256 toward zero
    assign v8       = $signed({1'b0, item.sample[7:0]}) - $signed(SAMPLE8_BIAS);
    assign mul_a    = item.is8 ? {{7{v8[8]}}, v8} : item.sample;
    assign mul_b    = $signed({1'b0, item.gain});
    assign prod     = mul_a * mul_b;
    assign prod_adj = prod + {19'd0, {8{prod[26]}}};
    assign v_calc   = item.is8 ? prod[17:0] : prod_adj[25:8];

    // pan shares, /128 toward zero
    assign pl     = v_reg * $signed({1'b0, left_reg});
    assign pr     = v_reg * $signed({1'b0, right_reg});
    assign pl_adj = pl + {20'd0, {7{pl[26]}}};
    assign pr_adj = pr + {20'd0, {7{pr[26]}}};
    assign dl     = pl_adj[25:7];
    assign dr     = pr_adj[25:7];

    assign item_ready = (state_reg == ST_IDLE);

    always_comb
    begin
        state_next     = state_reg;
        v_next         = v_reg;
        left_next      = left_reg;
        right_next     = right_reg;
        last_next      = last_reg;
        acc_l_next     = acc_l_reg;
        acc_r_next     = acc_r_reg;
        out_l_next     = out_l_reg;
        out_r_next     = out_r_reg;
        out_valid_next = out_valid_reg && !out_ready;
        case (state_reg)
            ST_IDLE:
            begin
                if (item_valid)
                begin
                    v_next     = v_calc;
                    left_next  = item.left_share;
                    right_next = item.right_share;
                    last_next  = item.last;
                    state_next = ST_ACC;
                end
            end
            ST_ACC:
            begin
                acc_l_next = acc_l_reg + {{13{dl[18]}}, dl};
                acc_r_next = acc_r_reg + {{13{dr[18]}}, dr};
                state_next = last_reg ? ST_OUT : ST_IDLE;
            end
            ST_OUT:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    out_l_next     = clip_sample(acc_l_reg, output_8bit);
                    out_r_next     = clip_sample(acc_r_reg, output_8bit);
                    out_valid_next = 1'b1;
                    acc_l_next     = '0;
                    acc_r_next     = '0;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            acc_l_reg     <= '0;
            acc_r_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            acc_l_reg     <= acc_l_next;
            acc_r_reg     <= acc_r_next;
            out_valid_reg <= out_valid_next;
            v_reg         <= v_next;
            left_reg      <= left_next;
            right_reg     <= right_next;
            last_reg      <= last_next;
            out_l_reg     <= out_l_next;
            out_r_reg     <= out_r_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign left_out  = out_l_reg;
    assign right_out = out_r_reg;

endmodule

>>> hw/rtl/stereo_pan_volume_mixer.sv
// stereo_pan_volume_mixer: top level, config registers and front/queue/back wiring.
// Depends on spvm_pkg, spvm_front, spvm_queue, spvm_back.
//
// Usage:
//   Slave stream: one beat per channel contribution of the current output frame;
//   tlast marks the last contribution of a frame, tuser flags an 8-bit sample.
//   Master stream: one beat per frame carrying the clipped left/right pair.
//   Config: APB-style; master_volume at 0x0, output_8bit at 0x4. Write only
//   while the block is idle.
// Data path:
//   The front end takes a beat every cycle while s_axis_tready is high, into a
//   two-stage pipeline (volume product, then gain division) and a
//   QUEUE_DEPTH-entry queue. The back end scales a contribution (ST_IDLE), then
//   pans and accumulates it (ST_ACC), and at frame end clips and loads the
//   output register (ST_OUT); it takes no new contribution until it has
//   finished with the previous one.
// Reset clears the pipeline, queue, accumulators and output valid; master
//   volume returns to 128, output mode to signed 16-bit.
// A stalled receiver holds the result in the output register; the back end
//   then waits at the next frame end and the queue and front end fill up
//   before s_axis_tready drops.

module stereo_pan_volume_mixer
    import spvm_pkg::*;
#(
    parameter int QUEUE_DEPTH = 2
)
(
    input  logic        clk,
    input  logic        rst_n,
    // slave stream
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [31:0] s_axis_tdata,   // sample_value[15:0], channel_volume[23:16], pan[31:24]
    input  logic [0:0]  s_axis_tuser,   // sample_is_8bit[0]
    input  logic        s_axis_tlast,
    // master stream
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [31:0] m_axis_tdata,   // left_out[15:0], right_out[31:16]
    // config port
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    logic [7:0]  master_volume_reg, master_volume_next;
    logic        output_8bit_reg, output_8bit_next;
    logic        cfg_wr;
    logic        reg_idx;

    logic        push_valid;
    logic        push_ready;
    spvm_item_t  push_item;
    logic        pop_valid;
    logic        pop_ready;
    spvm_item_t  pop_item;
    logic [15:0] left_out;
    logic [15:0] right_out;

    assign pready  = 1'b1;
    assign reg_idx = paddr[2];
    assign cfg_wr  = psel && penable && pwrite && pready;

    always_comb
    begin
        master_volume_next = master_volume_reg;
        output_8bit_next   = output_8bit_reg;
        if (cfg_wr)
        begin
            case (reg_idx)
                REG_MASTER_VOLUME: master_volume_next = pwdata[7:0];
                REG_OUTPUT_8BIT:   output_8bit_next   = pwdata[0];
                default:           master_volume_next = master_volume_reg;
            endcase
        end
    end

    always_comb
    begin
        case (reg_idx)
            REG_MASTER_VOLUME: prdata = {24'd0, master_volume_reg};
            REG_OUTPUT_8BIT:   prdata = {31'd0, output_8bit_reg};
            default:           prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            master_volume_reg <= MASTER_VOL_RST;
            output_8bit_reg   <= 1'b0;
        end
        else
        begin
            master_volume_reg <= master_volume_next;
            output_8bit_reg   <= output_8bit_next;
        end
    end

    spvm_front u_front (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (s_axis_tvalid),
        .in_ready       (s_axis_tready),
        .sample_value   ($signed(s_axis_tdata[15:0])),
        .sample_is_8bit (s_axis_tuser[0]),
        .channel_volume (s_axis_tdata[23:16]),
        .pan            ($signed(s_axis_tdata[31:24])),
        .last_of_frame  (s_axis_tlast),
        .master_volume  (master_volume_reg),
        .push_valid     (push_valid),
        .push_ready     (push_ready),
        .push_item      (push_item)
    );

    spvm_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_item  (push_item),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready),
        .pop_item   (pop_item)
    );

    spvm_back u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .item_valid  (pop_valid),
        .item_ready  (pop_ready),
        .item        (pop_item),
        .output_8bit (output_8bit_reg),
        .out_valid   (m_axis_tvalid),
        .out_ready   (m_axis_tready),
        .left_out    (left_out),
        .right_out   (right_out)
    );

    assign m_axis_tdata = {right_out, left_out};

endmodule

>>> tb/stereo_pan_volume_mixer_tb.sv
// Self-checking testbench for stereo_pan_volume_mixer: streams channel beats in frames,
// predicts each clipped stereo pair and compares it with the output stream.
// Depends on spvm_pkg and the stereo_pan_volume_mixer RTL.
`timescale 1ns / 100ps

module stereo_pan_volume_mixer_tb;
    import spvm_pkg::*;

    localparam int HOLD_CYCLES      = 300;
    localparam int STALL_LIMIT      = 2000;
    localparam int SETTLE_CYCLES    = 16;
    localparam int LONG_FRAME_BEATS = 40;
    localparam int PHASE_BEATS      = 60;

    typedef struct {
        logic signed [15:0] sample;
        logic               is8;
        logic [7:0]         volume;
        logic signed [7:0]  pan;
        logic               last;
    } channel_beat_t;

    typedef struct {
        logic [15:0] left;
        logic [15:0] right;
    } stereo_pair_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [31:0] s_axis_tdata = '0;   // sample_value[15:0], channel_volume[23:16], pan[31:24]
    logic [0:0]  s_axis_tuser = '0;   // sample_is_8bit[0]
    logic        s_axis_tlast = 1'b0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [31:0] m_axis_tdata;        // left_out[15:0], right_out[31:16]
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [2:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;

    // mixer prediction state
    logic [31:0]  mix_left_acc = '0;
    logic [31:0]  mix_right_acc = '0;
    logic [7:0]   cfg_master_volume = MASTER_VOL_RST;
    logic         cfg_out8 = 1'b0;
    stereo_pair_t expected_pairs[$];

    int error_count   = 0;
    int idle_cycles   = 0;
    int hold_requests = 0;
    int hold_granted  = 0;
    int hold_left     = 0;
    bit steady        = 1'b0;

    always #5 clk = ~clk;

    stereo_pan_volume_mixer DUT (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready)
    );

    function automatic logic [15:0] clip_to_output(logic [31:0] acc);
        longint level;
        longint clipped;
        level = longint'(signed'(acc));
        if (cfg_out8)
        begin
            level = level / 256;
            if (level > 127)
                clipped = 255;
            else if (level < -127)
                clipped = 0;
            else
                clipped = level + 127;
        end
        else
        begin
            if (level > 32767)
                clipped = 32767;
            else if (level < -32768)
                clipped = -32768;
            else
                clipped = level;
        end
        return clipped[15:0];
    endfunction

    task automatic mix_contribution(channel_beat_t b);
        longint       gain;
        longint       left_share;
        longint       right_share;
        longint       scaled;
        longint       delta_left;
        longint       delta_right;
        stereo_pair_t pair;
        gain = (longint'(b.volume) + 1) * 2 * longint'(cfg_master_volume) / 255;
        if (b.pan < 0)
        begin
            left_share  = 128;
            right_share = 128 + longint'(b.pan);
        end
        else
        begin
            left_share  = 128 - longint'(b.pan);
            right_share = 128;
        end
        if (b.is8)
            scaled = (longint'(b.sample[7:0]) - 127) * gain;
        else
            scaled = longint'(b.sample) * gain / 256;
        delta_left  = scaled * left_share / 128;
        delta_right = scaled * right_share / 128;
        mix_left_acc  = mix_left_acc + delta_left[31:0];
        mix_right_acc = mix_right_acc + delta_right[31:0];
        if (b.last)
        begin
            pair.left  = clip_to_output(mix_left_acc);
            pair.right = clip_to_output(mix_right_acc);
            expected_pairs.push_back(pair);
            mix_left_acc  = '0;
            mix_right_acc = '0;
        end
    endtask

    function automatic channel_beat_t make_beat(logic signed [15:0] sample, logic is8,
                                                logic [7:0] volume, logic signed [7:0] pan,
                                                logic last);
        channel_beat_t b;
        b.sample = sample;
        b.is8    = is8;
        b.volume = volume;
        b.pan    = pan;
        b.last   = last;
        return b;
    endfunction

    function automatic channel_beat_t random_beat();
        channel_beat_t b;
        if ($urandom_range(7) == 0)
        begin
            case ($urandom_range(2))
                0:       b.sample = 16'sh7FFF;
                1:       b.sample = 16'sh8000;
                default: b.sample = 16'sh0000;
            endcase
        end
        else
            b.sample = 16'($urandom);
        b.is8 = 1'($urandom_range(1));
        if ($urandom_range(7) == 0)
            b.volume = $urandom_range(1) ? 8'hFF : 8'h00;
        else
            b.volume = 8'($urandom);
        if ($urandom_range(7) == 0)
        begin
            case ($urandom_range(2))
                0:       b.pan = -8'sd128;
                1:       b.pan = 8'sd127;
                default: b.pan = 8'sd0;
            endcase
        end
        else
            b.pan = 8'($urandom);
        b.last = 1'b0;
        return b;
    endfunction

    task automatic send_beat(channel_beat_t b);
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {b.pan, b.volume, b.sample};
        s_axis_tuser  <= b.is8;
        s_axis_tlast  <= b.last;
        do
            @(posedge clk);
        while (!s_axis_tready);
        mix_contribution(b);
        if (!steady && $urandom_range(99) < 33)
        begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge clk);
        end
    endtask

    task automatic wait_mixer_idle();
        s_axis_tvalid <= 1'b0;
        while (expected_pairs.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_register(logic reg_index, logic [7:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {reg_index, 2'b00};
        pwdata  <= {24'($urandom), value};
        @(posedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        if (reg_index == REG_MASTER_VOLUME)
            cfg_master_volume = value;
        else
            cfg_out8 = value[0];
    endtask

    task automatic send_random_frames(int beat_count, int max_frame);
        int sent;
        int frame_left;
        channel_beat_t b;
        sent = 0;
        frame_left = 0;
        while (sent < beat_count || frame_left != 0)
        begin
            if (frame_left == 0)
                frame_left = ($urandom_range(9) < 7) ? $urandom_range(1, max_frame)
                                                     : $urandom_range(1, 4 * max_frame);
            b = random_beat();
            b.last = (frame_left == 1);
            frame_left--;
            send_beat(b);
            sent++;
        end
    endtask

    task automatic report_mismatch(string what, logic [15:0] got, logic [15:0] want);
        $display("MISMATCH %s: got %h, expected %h at %0t", what, got, want, $realtime);
        error_count++;
    endtask

    // output stream compare
    always @(posedge clk)
    begin : check_pair
        stereo_pair_t want;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            if (expected_pairs.size() == 0)
                report_mismatch("result beat with no frame pending", m_axis_tdata[15:0], '0);
            else
            begin
                want = expected_pairs.pop_front();
                if (m_axis_tdata[15:0] !== want.left)
                    report_mismatch("left_out", m_axis_tdata[15:0], want.left);
                if (m_axis_tdata[31:16] !== want.right)
                    report_mismatch("right_out", m_axis_tdata[31:16], want.right);
            end
        end
    end

    // receiver: random stalls, always ready in steady mode, or a long hold-off on request
    always @(posedge clk)
    begin
        if (hold_left > 0)
        begin
            m_axis_tready <= 1'b0;
            hold_left     <= hold_left - 1;
        end
        else if (hold_granted != hold_requests)
        begin
            hold_granted  <= hold_requests;
            hold_left     <= HOLD_CYCLES;
            m_axis_tready <= 1'b0;
        end
        else if (steady)
            m_axis_tready <= 1'b1;
        else
            m_axis_tready <= ($urandom_range(99) >= 33);
    end

    always @(posedge clk)
    begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= STALL_LIMIT)
        begin
            $display("Test completed with failures");
            $finish;
        end
    end

    task automatic test_directed_corners();
        // reset config: master volume 128, signed 16-bit output
        send_beat(make_beat(16'sh7FFF, 1'b0, 8'hFF, 8'sd0, 1'b1));
        send_beat(make_beat(16'sh8000, 1'b0, 8'hFF, -8'sd128, 1'b1));
        send_beat(make_beat(16'sh8000, 1'b0, 8'hFF, 8'sd127, 1'b1));
        send_beat(make_beat(16'sd1234, 1'b0, 8'h00, 8'sd0, 1'b1));
        send_beat(make_beat(16'sh00FF, 1'b1, 8'hFF, 8'sd0, 1'b1));
        send_beat(make_beat(16'sh0000, 1'b1, 8'hFF, -8'sd1, 1'b1));
        // 8-bit sample with junk in the upper byte
        send_beat(make_beat(16'shA580, 1'b1, 8'h80, 8'sd64, 1'b1));
        // multi-beat frames driving both saturation limits
        repeat (3) send_beat(make_beat(16'sh7FFF, 1'b0, 8'hFF, 8'sd0, 1'b0));
        send_beat(make_beat(16'sh7FFF, 1'b0, 8'hFF, 8'sd0, 1'b1));
        repeat (2) send_beat(make_beat(16'sh8000, 1'b0, 8'hFF, -8'sd50, 1'b0));
        send_beat(make_beat(16'sh8000, 1'b1, 8'hFF, 8'sd50, 1'b1));
        wait_mixer_idle();

        write_register(REG_MASTER_VOLUME, 8'hFF);
        write_register(REG_OUTPUT_8BIT, 8'h01);
        send_beat(make_beat(16'sh00FF, 1'b1, 8'hFF, 8'sd0, 1'b1));
        send_beat(make_beat(16'sh0000, 1'b1, 8'hFF, 8'sd0, 1'b1));
        send_beat(make_beat(16'sd200, 1'b0, 8'd10, 8'sd0, 1'b1));
        send_beat(make_beat(-16'sd100, 1'b0, 8'd3, -8'sd7, 1'b1));
        // frame left open across a config write
        send_beat(make_beat(16'sh7FFF, 1'b0, 8'hFF, 8'sd0, 1'b0));
        wait_mixer_idle();

        write_register(REG_MASTER_VOLUME, 8'h00);
        send_beat(make_beat(16'sh7FFF, 1'b0, 8'hFF, 8'sd0, 1'b1));
        send_beat(make_beat(16'sh00FF, 1'b1, 8'hFF, 8'sd0, 1'b1));
        wait_mixer_idle();

        write_register(REG_MASTER_VOLUME, MASTER_VOL_RST);
        write_register(REG_OUTPUT_8BIT, 8'h00);
    endtask

    task automatic test_volume_and_mode_sweep();
        logic [7:0] sweep_volume [6];
        logic       sweep_out8 [6];
        sweep_volume = '{8'd0, 8'd255, 8'd255, 8'd1, 8'd128, 8'($urandom)};
        sweep_out8   = '{1'b0, 1'b1, 1'b0, 1'b1, 1'b0, 1'($urandom_range(1))};
        for (int phase = 0; phase < 6; phase++)
        begin
            write_register(REG_MASTER_VOLUME, sweep_volume[phase]);
            write_register(REG_OUTPUT_8BIT, {7'($urandom), sweep_out8[phase]});
            steady = (phase == 2);
            send_random_frames(PHASE_BEATS, 4);
            steady = 1'b0;
            wait_mixer_idle();
        end
    endtask

    task automatic test_output_backpressure();
        write_register(REG_MASTER_VOLUME, 8'($urandom));
        write_register(REG_OUTPUT_8BIT, 8'h00);
        hold_requests++;
        steady = 1'b1;
        send_random_frames(60, 2);
        steady = 1'b0;
        wait_mixer_idle();
    endtask

    task automatic test_long_frame();
        // one long frame of full-scale negative beats drives the sums far below the clip limit
        write_register(REG_MASTER_VOLUME, 8'hFF);
        write_register(REG_OUTPUT_8BIT, 8'h00);
        steady = 1'b1;
        for (int i = 0; i < LONG_FRAME_BEATS; i++)
            send_beat(make_beat(16'sh8000, 1'b0, 8'hFF, 8'sd0, i == LONG_FRAME_BEATS - 1));
        steady = 1'b0;
        wait_mixer_idle();
    endtask

    initial
    begin
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed_corners();
        test_volume_and_mode_sweep();
        test_output_backpressure();
        test_long_frame();
        if (error_count == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule
